// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge outside reset
`define DHJT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr must never be true outside reset
`define DHJT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/dhjt_pkg.sv -----
package dhjt_pkg;

    // angle units: 1/128 degree
    localparam logic [16:0] FULL_TURN    = 17'd46080;
    localparam logic [16:0] QUARTER_TURN = 17'd11520;
    localparam logic [16:0] HALF_TURN    = 17'd23040;
    localparam logic [16:0] THREE_QUARTER = 17'd34560;

    localparam int unsigned SINE_LAT = 15;
    localparam int unsigned PIPE_LAT = SINE_LAT + 3;

    localparam logic [30:0] QONE = 31'h4000_0000;

    // pi/23040 in Q30 split as 146408 + 19106/23040
    localparam logic [17:0] RAD_INT  = 18'd146408;
    localparam logic [14:0] RAD_FRAC = 15'd19106;
    localparam logic [13:0] RAD_BIAS = 14'd11520;
    localparam logic [63:0] DIV45_M  = ((64'd1 << 25) + 64'd44) / 64'd45;

    // Horner divisors 156,110,72,42,20,6 as shift + odd reciprocal
    localparam logic [63:0] HM0 = ((64'd1 << 36) + 64'd38) / 64'd39;
    localparam logic [63:0] HM1 = ((64'd1 << 37) + 64'd54) / 64'd55;
    localparam logic [63:0] HM2 = ((64'd1 << 33) + 64'd8) / 64'd9;
    localparam logic [63:0] HM3 = ((64'd1 << 36) + 64'd20) / 64'd21;
    localparam logic [63:0] HM4 = ((64'd1 << 33) + 64'd4) / 64'd5;
    localparam logic [63:0] HM5 = ((64'd1 << 33) + 64'd2) / 64'd3;

    typedef enum logic [1:0] {
        CFG_TWIST  = 2'd0,
        CFG_LENGTH = 2'd1,
        CFG_OFFSET = 2'd2
    } t_cfg_index;

    localparam logic [1:0]  ROW_LAST = 2'd3;
    localparam logic [23:0] TR_ONE   = 24'd256;

    typedef struct packed {
        logic [2:0][2:0][15:0] rot;  // [row][col]
        logic [2:0][23:0]      tr;   // [row]
    } t_matrix;

    typedef struct packed {
        logic done;   // last row of held matrix leaves this cycle
        logic mid;    // rows 1..3 still to go
    } t_row_stat;

    function automatic logic [31:0] horner_div(input logic [31:0] u, input logic [2:0] step);
        logic [63:0] prod;
        logic [31:0] q;
        begin
            case (step)
                3'd0: begin prod = 64'(u >> 2) * HM0; q = 32'(prod >> 36); end
                3'd1: begin prod = 64'(u >> 1) * HM1; q = 32'(prod >> 37); end
                3'd2: begin prod = 64'(u >> 3) * HM2; q = 32'(prod >> 33); end
                3'd3: begin prod = 64'(u >> 1) * HM3; q = 32'(prod >> 36); end
                3'd4: begin prod = 64'(u >> 2) * HM4; q = 32'(prod >> 33); end
                3'd5: begin prod = 64'(u >> 1) * HM5; q = 32'(prod >> 33); end
                default: begin prod = '0; q = '0; end
            endcase
            return q;
        end
    endfunction

    function automatic logic [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'h7fff;
        else if (v < -64'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    function automatic logic [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'h7f_ffff;
        else if (v < -64'sd8388608)
            return 24'h80_0000;
        else
            return v[23:0];
    endfunction

endpackage

// ----- rtl/dhjt_sine.sv -----
module dhjt_sine #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [13:0]               i_rem,
    output logic [TRIG_FRAC_BITS:0]   o_value
);
    import dhjt_pkg::*;

    localparam int SH = 30 - TRIG_FRAC_BITS;
    localparam logic [31:0] RND = (SH == 0) ? 32'd0 : (32'd1 << ((SH == 0) ? 0 : SH - 1));

    logic [30:0] r_a;
    logic [18:0] r_w;
    logic [30:0] r_x1;
    logic [31:0] r_s2;
    logic [30:0] r_x2;
    logic [31:0] r_sc [0:10];
    logic [30:0] r_xc [0:10];
    logic [30:0] r_t  [0:5];
    logic [31:0] r_u  [1:5];
    logic [TRIG_FRAC_BITS:0] r_out;

    logic [31:0] n_q45;
    logic [31:0] n_d0;
    logic [61:0] n_sq;
    logic [61:0] n_fin;
    logic [31:0] n_v;
    logic [31:0] n_vc;
    logic [31:0] n_vr;

    always_comb begin
        n_q45 = 32'((64'(r_w) * DIV45_M) >> 25);
        n_sq  = 62'(r_x1) * 62'(r_x1);
        n_d0  = horner_div(r_s2, 3'd0);
        n_fin = 62'(r_xc[10]) * 62'(r_t[5]);
        n_v   = 32'(n_fin >> 30);
        n_vc  = (n_v > 32'(QONE)) ? 32'(QONE) : n_v;
        n_vr  = (n_vc + RND) >> SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= 31'(32'(i_rem) * 32'(RAD_INT));
            r_w      <= 19'((32'(i_rem) * 32'(RAD_FRAC) + 32'(RAD_BIAS)) >> 9);
            r_x1     <= r_a + 31'(n_q45);
            r_s2     <= 32'(n_sq >> 30);
            r_x2     <= r_x1;
            r_sc[0]  <= r_s2;
            r_xc[0]  <= r_x2;
            r_t[0]   <= (n_d0 >= 32'(QONE)) ? 31'd0 : 31'(32'(QONE) - n_d0);
            r_out    <= n_vr[TRIG_FRAC_BITS:0];
        end
    end

    // one multiply stage and one divide stage per Horner term
    for (genvar k = 1; k <= 5; k++) begin : g_term
        logic [62:0] n_prod;
        logic [31:0] n_d;
        always_comb begin
            n_prod = 63'(r_sc[2*k-2]) * 63'(r_t[k-1]);
            n_d    = horner_div(r_u[k], 3'(k));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_u[k]      <= 32'(n_prod >> 30);
                r_sc[2*k-1] <= r_sc[2*k-2];
                r_xc[2*k-1] <= r_xc[2*k-2];
                r_t[k]      <= (n_d >= 32'(QONE)) ? 31'd0 : 31'(32'(QONE) - n_d);
                r_sc[2*k]   <= r_sc[2*k-1];
                r_xc[2*k]   <= r_xc[2*k-1];
            end
        end
    end

    assign o_value = r_out;

endmodule

// ----- rtl/dhjt_matrix.sv -----
module dhjt_matrix #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [TRIG_FRAC_BITS:0]     i_sin_t,
    input  logic [TRIG_FRAC_BITS:0]     i_cos_t,
    input  logic [TRIG_FRAC_BITS:0]     i_sin_a,
    input  logic [TRIG_FRAC_BITS:0]     i_cos_a,
    input  logic [1:0]                  i_q_t,
    input  logic [1:0]                  i_q_a,
    input  logic signed [23:0]          i_link_length,
    input  logic signed [23:0]          i_link_offset,
    output dhjt_pkg::t_matrix           o_matrix
);
    import dhjt_pkg::*;

    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = 2 * F + 2;
    localparam int RW = F + 25;
    localparam logic [63:0] HALF = 64'd1 << (F - 1);

    typedef struct packed {
        logic [F:0] mag;
        logic       neg;
    } t_trig;

    function automatic t_trig quad_sin(input logic [1:0] q, input logic [F:0] sr,
                                       input logic [F:0] cr);
        t_trig v;
        case (q)
            2'd0:    begin v.mag = sr; v.neg = 1'b0; end
            2'd1:    begin v.mag = cr; v.neg = 1'b0; end
            2'd2:    begin v.mag = sr; v.neg = 1'b1; end
            default: begin v.mag = cr; v.neg = 1'b1; end
        endcase
        return v;
    endfunction

    function automatic t_trig quad_cos(input logic [1:0] q, input logic [F:0] sr,
                                       input logic [F:0] cr);
        t_trig v;
        case (q)
            2'd0:    begin v.mag = cr; v.neg = 1'b0; end
            2'd1:    begin v.mag = sr; v.neg = 1'b1; end
            2'd2:    begin v.mag = cr; v.neg = 1'b1; end
            default: begin v.mag = sr; v.neg = 1'b0; end
        endcase
        return v;
    endfunction

    function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
        logic signed [63:0] v;
        v = signed'(m);
        return neg ? -v : v;
    endfunction

    // product rounded half away from zero
    function automatic logic signed [63:0] round_prod(input logic [63:0] m, input logic neg);
        logic [63:0] p;
        p = (m + HALF) >> F;
        return signed_of(p, neg);
    endfunction

    t_trig n_st, n_ct, n_sa, n_ca;
    t_trig r_st, r_ct, r_sa, r_ca;
    logic [23:0] n_rmag;
    logic [TW-1:0] r_stca, r_stsa, r_ctca, r_ctsa;
    logic [RW-1:0] r_rct, r_rst;
    logic r_rneg;
    t_matrix n_m, r_m;

    always_comb begin
        n_st   = quad_sin(i_q_t, i_sin_t, i_cos_t);
        n_ct   = quad_cos(i_q_t, i_sin_t, i_cos_t);
        n_sa   = quad_sin(i_q_a, i_sin_a, i_cos_a);
        n_ca   = quad_cos(i_q_a, i_sin_a, i_cos_a);
        n_rmag = i_link_length[23] ? 24'(-i_link_length) : 24'(i_link_length);
    end

    always_comb begin
        n_m = '0;
        n_m.rot[0][0] = sat16(signed_of(64'(r_ct.mag), r_ct.neg));
        n_m.rot[0][1] = sat16(round_prod(64'(r_stca), !(r_st.neg ^ r_ca.neg)));
        n_m.rot[0][2] = sat16(round_prod(64'(r_stsa), r_st.neg ^ r_sa.neg));
        n_m.tr[0]     = sat24(round_prod(64'(r_rct), r_rneg ^ r_ct.neg));
        n_m.rot[1][0] = sat16(signed_of(64'(r_st.mag), r_st.neg));
        n_m.rot[1][1] = sat16(round_prod(64'(r_ctca), r_ct.neg ^ r_ca.neg));
        n_m.rot[1][2] = sat16(round_prod(64'(r_ctsa), !(r_ct.neg ^ r_sa.neg)));
        n_m.tr[1]     = sat24(round_prod(64'(r_rst), r_rneg ^ r_st.neg));
        n_m.rot[2][1] = sat16(signed_of(64'(r_sa.mag), r_sa.neg));
        n_m.rot[2][2] = sat16(signed_of(64'(r_ca.mag), r_ca.neg));
        n_m.tr[2]     = i_link_offset;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st   <= n_st;
            r_ct   <= n_ct;
            r_sa   <= n_sa;
            r_ca   <= n_ca;
            r_stca <= TW'(n_st.mag) * TW'(n_ca.mag);
            r_stsa <= TW'(n_st.mag) * TW'(n_sa.mag);
            r_ctca <= TW'(n_ct.mag) * TW'(n_ca.mag);
            r_ctsa <= TW'(n_ct.mag) * TW'(n_sa.mag);
            r_rct  <= RW'(n_rmag) * RW'(n_ct.mag);
            r_rst  <= RW'(n_rmag) * RW'(n_st.mag);
            r_rneg <= i_link_length[23];
            r_m    <= n_m;
        end
    end

    assign o_matrix = r_m;

endmodule

// ----- rtl/dhjt_row_out.sv -----
module dhjt_row_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mvalid,
    input  dhjt_pkg::t_matrix   i_matrix,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_row_index,
    output logic [15:0]         o_col_zero,
    output logic [15:0]         o_col_one,
    output logic [15:0]         o_col_two,
    output logic [23:0]         o_col_three,
    output logic                o_last_row,
    output dhjt_pkg::t_row_stat o_stat
);
    import dhjt_pkg::*;

    logic        r_valid;
    logic [1:0]  r_row;
    logic [1:0]  r_idx;
    logic [15:0] r_c0, r_c1, r_c2;
    logic [23:0] r_c3;
    logic        r_last;
    logic        n_adv;
    logic        n_emit;

    assign n_adv  = !r_valid || i_out_ready;
    assign n_emit = i_mvalid && n_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= '0;
        end else if (n_emit) begin
            r_valid <= 1'b1;
            r_row   <= r_row + 2'd1;
        end else if (n_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_idx  <= r_row;
            r_last <= (r_row == ROW_LAST);
            if (r_row == ROW_LAST) begin
                r_c0 <= '0;
                r_c1 <= '0;
                r_c2 <= '0;
                r_c3 <= TR_ONE;
            end else begin
                r_c0 <= i_matrix.rot[r_row][0];
                r_c1 <= i_matrix.rot[r_row][1];
                r_c2 <= i_matrix.rot[r_row][2];
                r_c3 <= i_matrix.tr[r_row];
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_row_index = r_idx;
    assign o_col_zero  = r_c0;
    assign o_col_one   = r_c1;
    assign o_col_two   = r_c2;
    assign o_col_three = r_c3;
    assign o_last_row  = r_last;
    assign o_stat.done = n_emit && (r_row == ROW_LAST);
    assign o_stat.mid  = (r_row != 2'd0);

endmodule

// ----- rtl/dh_joint_transform_core.sv -----
// An accepted word passes the input register, the sine lanes, both matrix
// registers and the row register before row 0 shows. Four row words per angle;
// the row serializer holds the finished matrix for four output beats.
// The sine pipeline (four lanes, 15 stages) takes a new angle whenever the matrix frees.
// Reset is synchronous, active low: clears valid bits, row counter and config registers.
`include "assert_macros.svh"

module dh_joint_transform_core #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_joint_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_row_index,
    output logic signed [15:0] o_col_zero,
    output logic signed [15:0] o_col_one,
    output logic signed [15:0] o_col_two,
    output logic signed [23:0] o_col_three,
    output logic               o_last_row
);
    import dhjt_pkg::*;

    typedef struct packed {
        logic [1:0]  q;
        logic [13:0] rem;
    } t_red;

    function automatic t_red reduce(input logic [15:0] ang);
        logic [16:0] a;
        t_red r;
        a = ang[15] ? 17'($signed({ang[15], ang}) + 17'sd46080) : {1'b0, ang};
        if (a >= THREE_QUARTER) begin
            r.q = 2'd3; r.rem = 14'(a - THREE_QUARTER);
        end else if (a >= HALF_TURN) begin
            r.q = 2'd2; r.rem = 14'(a - HALF_TURN);
        end else if (a >= QUARTER_TURN) begin
            r.q = 2'd1; r.rem = 14'(a - QUARTER_TURN);
        end else begin
            r.q = 2'd0; r.rem = a[13:0];
        end
        return r;
    endfunction

    logic signed [15:0] r_twist;
    logic signed [23:0] r_length;
    logic signed [23:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twist  <= '0;
            r_length <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TWIST:  r_twist  <= i_cfg_data[15:0];
                CFG_LENGTH: r_length <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic        n_en;
    logic        n_accept;
    t_row_stat   n_stat;
    t_red        n_rt, n_ra;
    logic [PIPE_LAT-1:0] r_vld;
    logic [13:0] r_rem [0:3];
    // one entry per sine stage plus the input register stage
    logic [3:0]  r_qd  [0:SINE_LAT];
    logic [TRIG_FRAC_BITS:0] n_sine [0:3];
    t_matrix     n_matrix;

    // whole pipe moves together; it waits only while the matrix is being sent
    assign n_en       = !r_vld[PIPE_LAT-1] || n_stat.done;
    assign n_accept   = i_in_valid && n_en;
    assign o_in_ready = n_en;
    assign n_rt       = reduce(i_joint_angle);
    assign n_ra       = reduce(r_twist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (n_en)
            r_vld <= {r_vld[PIPE_LAT-2:0], n_accept};
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_rem[0] <= n_rt.rem;
            r_rem[1] <= 14'(QUARTER_TURN) - n_rt.rem;
            r_rem[2] <= n_ra.rem;
            r_rem[3] <= 14'(QUARTER_TURN) - n_ra.rem;
            r_qd[0]  <= {n_rt.q, n_ra.q};
            for (int k = 1; k <= SINE_LAT; k++)
                r_qd[k] <= r_qd[k-1];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        dhjt_sine #(
            .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
        ) u_sine (
            .i_clk   (i_clk),
            .i_en    (n_en),
            .i_rem   (r_rem[g]),
            .o_value (n_sine[g])
        );
    end

    dhjt_matrix #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_matrix (
        .i_clk         (i_clk),
        .i_en          (n_en),
        .i_sin_t       (n_sine[0]),
        .i_cos_t       (n_sine[1]),
        .i_sin_a       (n_sine[2]),
        .i_cos_a       (n_sine[3]),
        .i_q_t         (r_qd[SINE_LAT][3:2]),
        .i_q_a         (r_qd[SINE_LAT][1:0]),
        .i_link_length (r_length),
        .i_link_offset (r_offset),
        .o_matrix      (n_matrix)
    );

    dhjt_row_out u_row_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mvalid    (r_vld[PIPE_LAT-1]),
        .i_matrix    (n_matrix),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_row_index (o_row_index),
        .o_col_zero  (o_col_zero),
        .o_col_one   (o_col_one),
        .o_col_two   (o_col_two),
        .o_col_three (o_col_three),
        .o_last_row  (o_last_row),
        .o_stat      (n_stat)
    );

    `DHJT_ASSERT(a_row_order, i_clk, i_rst_n, (o_out_valid && i_out_ready) |=> (!o_out_valid || o_row_index == 2'($past(o_row_index) + 2'd1)), "rows out of order")
    `DHJT_NEVER(a_mid_matrix_held, i_clk, i_rst_n, n_stat.mid && !r_vld[PIPE_LAT-1], "matrix dropped mid-send")

endmodule
